### rtl/plsched_pkg.sv
// Shared types and constants for the piecewise-linear schedule block.
package plsched_pkg;

    localparam int TIME_W     = 17;
    localparam int LEVEL_W    = 7;
    localparam int ZONE_W     = 4;
    localparam int HOURS_W    = 5;
    localparam int CFG_W      = 24;
    localparam int CFG_AW     = 3;
    localparam int TS_W       = 19;
    localparam int NUM_W      = 24;
    localparam int MAX_POINTS = 5;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam int SECS_PER_HOUR = 3600;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(100);

    typedef enum logic [CFG_AW-1:0] {
        REG_POINT_ZERO  = 3'd0,
        REG_POINT_ONE   = 3'd1,
        REG_POINT_TWO   = 3'd2,
        REG_POINT_THREE = 3'd3,
        REG_POINT_FOUR  = 3'd4,
        REG_ZONE_HOURS  = 3'd5,
        REG_SCHED_ON    = 3'd6,
        REG_LIGHT_ZONE  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               bypass;
        logic [LEVEL_W-1:0] level;
    } t_div_side;

endpackage

### rtl/plsched_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module plsched_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [plsched_pkg::NUM_W-1:0]   i_num,
    input  logic [plsched_pkg::TIME_W-1:0]  i_den,
    input  plsched_pkg::t_div_side      i_side,
    output logic                        o_valid,
    output logic [plsched_pkg::LEVEL_W-1:0] o_quo,
    output plsched_pkg::t_div_side      o_side
);
    import plsched_pkg::*;

    localparam int QW = LEVEL_W;

    logic              r_vld  [QW];
    logic [QW-1:0]     r_quo  [QW];
    t_div_side         r_side [QW];
    logic [NUM_W-1:0]  r_rem  [QW-1];
    logic [TIME_W-1:0] r_den  [QW-1];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic              w_vld_in;
        logic [QW-1:0]     w_quo_in;
        t_div_side         w_side_in;
        logic [NUM_W-1:0]  w_rem_in;
        logic [TIME_W-1:0] w_den_in;
        logic [NUM_W-1:0]  w_shift;
        logic              w_take;
        logic [QW-1:0]     n_quo;

        if (s == 0) begin : g_first
            assign w_vld_in  = i_valid;
            assign w_quo_in  = '0;
            assign w_side_in = i_side;
            assign w_rem_in  = i_num;
            assign w_den_in  = i_den;
        end else begin : g_next
            assign w_vld_in  = r_vld[s-1];
            assign w_quo_in  = r_quo[s-1];
            assign w_side_in = r_side[s-1];
            assign w_rem_in  = r_rem[s-1];
            assign w_den_in  = r_den[s-1];
        end

        always_comb begin
            w_shift = NUM_W'(w_den_in) << (QW - 1 - s);
            w_take  = (w_rem_in >= w_shift);
            n_quo   = w_quo_in;
            n_quo[QW-1-s] = w_take;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s]  <= n_quo;
                r_side[s] <= w_side_in;
            end
        end

        if (s < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= w_take ? (w_rem_in - w_shift) : w_rem_in;
                    r_den[s] <= w_den_in;
                end
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

### rtl/piecewise_linear_schedule.sv
// A result passes stages 1 to 5, the divider and the output stage to the master side.
// Throughput: one transaction per cycle; the whole pipeline holds while the output stalls.
// Depth is set by 6 arithmetic stages plus a 7-stage divider, one quotient bit per stage.
// Reset (synchronous, active low) clears all valid bits and all configuration registers,
// which leaves the schedule disabled until written.
module piecewise_linear_schedule #(
    parameter int NUM_POINTS = 5
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [plsched_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  logic [plsched_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [16:0] day_seconds, [23:17] zero
    input  logic [plsched_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [6:0] temp_level, [10:7] target_zone, [15:11] zero
    output logic [plsched_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import plsched_pkg::*;

    localparam int NSEG = NUM_POINTS - 1;
    localparam int SELW = (NSEG > 1) ? $clog2(NSEG) : 1;

    // configuration
    logic [CFG_W-1:0]          r_point [NUM_POINTS];
    logic signed [HOURS_W-1:0] r_zone_hours;
    logic                      r_sched_on;
    logic [ZONE_W-1:0]         r_light_zone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_POINTS; k++) r_point[k] <= '0;
            r_zone_hours <= '0;
            r_sched_on   <= 1'b0;
            r_light_zone <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ZONE_HOURS: r_zone_hours <= i_cfg_wdata[HOURS_W-1:0];
                REG_SCHED_ON:   r_sched_on   <= i_cfg_wdata[0];
                REG_LIGHT_ZONE: r_light_zone <= i_cfg_wdata[ZONE_W-1:0];
                default: begin
                    for (int k = 0; k < NUM_POINTS; k++) begin
                        if (i_cfg_addr == CFG_AW'(k)) r_point[k] <= i_cfg_wdata;
                    end
                end
            endcase
        end
    end

    function automatic logic [TIME_W-1:0] pt_time(input logic [CFG_W-1:0] p);
        return p[TIME_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] pt_level(input logic [CFG_W-1:0] p);
        return p[TIME_W +: LEVEL_W];
    endfunction

    logic w_en;
    logic r_out_valid;
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;

    // stage 1: shifted time
    logic                   r1_vld;
    logic signed [TS_W-1:0] r1_t;
    logic signed [TS_W-1:0] w_offs;

    assign w_offs = TS_W'(r_zone_hours) * $signed(TS_W'(SECS_PER_HOUR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else if (w_en) r1_vld <= s_axis_tvalid && r_sched_on;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r1_t <= $signed({2'b00, s_axis_tdata[TIME_W-1:0]}) + w_offs;
    end

    // stage 2: first matching segment
    logic                   r2_vld;
    logic signed [TS_W-1:0] r2_t;
    logic [SELW-1:0]        r2_sel;
    logic                   r2_found;
    logic [SELW-1:0]        n_sel;
    logic                   n_found;

    always_comb begin
        n_sel   = '0;
        n_found = 1'b0;
        for (int k = NSEG - 1; k >= 0; k--) begin
            if (r1_t >= $signed({2'b00, pt_time(r_point[k])}) &&
                r1_t <= $signed({2'b00, pt_time(r_point[k+1])})) begin
                n_sel   = SELW'(k);
                n_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else if (w_en) r2_vld <= r1_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_t     <= r1_t;
            r2_sel   <= n_sel;
            r2_found <= n_found;
        end
    end

    // stage 3: segment operands
    logic               r3_vld;
    logic [TIME_W-1:0]  r3_span;
    logic [TIME_W-1:0]  r3_dt;
    logic [LEVEL_W-1:0] r3_l0;
    logic [LEVEL_W-1:0] r3_l1;
    t_div_side          r3_side;
    logic [TIME_W-1:0]  w_h0;
    logic [TIME_W-1:0]  w_h1;
    logic [LEVEL_W-1:0] w_l0;
    logic [LEVEL_W-1:0] w_l1;
    logic [TIME_W-1:0]  w_span;
    logic [TS_W-1:0]    w_dt;

    always_comb begin
        w_h0 = '0;
        w_h1 = '0;
        w_l0 = '0;
        w_l1 = '0;
        for (int k = 0; k < NSEG; k++) begin
            if (r2_sel == SELW'(k)) begin
                w_h0 = pt_time(r_point[k]);
                w_h1 = pt_time(r_point[k+1]);
                w_l0 = pt_level(r_point[k]);
                w_l1 = pt_level(r_point[k+1]);
            end
        end
        w_span = w_h1 - w_h0;
        w_dt   = r2_t - $signed({2'b00, w_h0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else if (w_en) r3_vld <= r2_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_span        <= w_span;
            r3_dt          <= w_dt[TIME_W-1:0];
            r3_l0          <= w_l0;
            r3_l1          <= w_l1;
            r3_side.bypass <= !r2_found || (w_span == '0);
            r3_side.level  <= r2_found ? w_l0 : pt_level(r_point[NUM_POINTS-1]);
        end
    end

    // stage 4: products
    logic                          r4_vld;
    logic [NUM_W-1:0]              r4_pa;
    logic signed [LEVEL_W+TIME_W+1:0] r4_pb;
    logic [TIME_W-1:0]             r4_span;
    t_div_side                     r4_side;
    logic signed [LEVEL_W:0]       w_dl;

    assign w_dl = $signed({1'b0, r3_l1}) - $signed({1'b0, r3_l0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else if (w_en) r4_vld <= r3_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_pa   <= NUM_W'(r3_l0) * NUM_W'(r3_span);
            r4_pb   <= w_dl * $signed({1'b0, r3_dt});
            r4_span <= r3_span;
            r4_side <= r3_side;
        end
    end

    // stage 5: numerator, nonnegative and below 128 * span
    logic                             r5_vld;
    logic [NUM_W-1:0]                 r5_num;
    logic [TIME_W-1:0]                r5_span;
    t_div_side                        r5_side;
    logic signed [LEVEL_W+TIME_W+1:0] w_num;

    assign w_num = $signed({2'b00, r4_pa}) + r4_pb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_vld <= 1'b0;
        else if (w_en) r5_vld <= r4_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_num  <= w_num[NUM_W-1:0];
            r5_span <= r4_span;
            r5_side <= r4_side;
        end
    end

    // divider
    logic               w_div_vld;
    logic [LEVEL_W-1:0] w_div_quo;
    t_div_side          w_div_side;

    plsched_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r5_vld),
        .i_num   (r5_num),
        .i_den   (r5_span),
        .i_side  (r5_side),
        .o_valid (w_div_vld),
        .o_quo   (w_div_quo),
        .o_side  (w_div_side)
    );

    // output stage: clamp and tag
    logic [LEVEL_W-1:0]     w_level;
    logic [OUT_TDATA_W-1:0] r_out_data;

    assign w_level = w_div_side.bypass ? w_div_side.level : w_div_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_en) r_out_valid <= w_div_vld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= OUT_TDATA_W'({r_light_zone,
                                        (w_level > LEVEL_MAX) ? LEVEL_MAX : w_level});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### rtl/plsched_chk.sv
// Port-level checker for the piecewise-linear schedule, bound to the top level.
module plsched_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_we,
    input logic [plsched_pkg::CFG_AW-1:0]      i_cfg_addr,
    input logic [plsched_pkg::CFG_W-1:0]       i_cfg_wdata,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [plsched_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import plsched_pkg::*;

    logic [ZONE_W-1:0] r_zone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_zone <= '0;
        else if (i_cfg_we && i_cfg_addr == REG_LIGHT_ZONE) r_zone <= i_cfg_wdata[ZONE_W-1:0];
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_level_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[LEVEL_W-1:0] <= LEVEL_MAX)
        else $error("level above clamp");

    a_zone_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[LEVEL_W +: ZONE_W] == r_zone)
        else $error("zone tag mismatch");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output changed");

endmodule

bind piecewise_linear_schedule plsched_chk u_plsched_chk (.*);
